FILE: design/imu_packet_deframer_defines.svh
// Assertion macros for the packet deframer.
`ifndef IMU_PACKET_DEFRAMER_DEFINES_SVH
`define IMU_PACKET_DEFRAMER_DEFINES_SVH

`ifndef SYNTH

`define IPD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

`define IPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`else

`define IPD_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define IPD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/imu_pd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package imu_pd_pkg;

    localparam int PKT_LEN    = 74;
    localparam int ADDR_W     = 7;
    localparam int NUM_FIELDS = 31;
    localparam int ID_W       = 5;

    localparam logic [7:0] DLE_BYTE = 8'h10;
    localparam logic [7:0] STX_BYTE = 8'h02;
    localparam logic [7:0] ETX_BYTE = 8'h03;

    localparam logic [ADDR_W-1:0] HDR_POS    = 7'd0;
    localparam logic [ADDR_W-1:0] STX_POS    = 7'd1;
    localparam logic [ADDR_W-1:0] BODY_POS   = 7'd2;
    localparam logic [ADDR_W-1:0] SUM_FIRST  = 7'd3;
    localparam logic [ADDR_W-1:0] FOOTER_POS = 7'd71;
    localparam logic [ADDR_W-1:0] ETX_POS    = 7'd72;
    localparam logic [ADDR_W-1:0] BCC_POS    = 7'd73;

    localparam logic [ID_W-1:0] LAST_ID = 5'd30;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_FIELD = 2'd0;
    localparam t_kind KIND_CSUM  = 2'd1;
    localparam t_kind KIND_FRAME = 2'd2;

    // Store write request from the parser.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr_req;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_rd_req;

    // Parser event: go starts the field readout, err posts one error word.
    typedef struct packed {
        logic  go;
        logic  err;
        t_kind kind;
    } t_evt;

    // last_byte is the field size minus one.
    typedef struct packed {
        logic [ADDR_W-1:0] offset;
        logic [1:0]        last_byte;
        logic              is_signed;
    } t_field_desc;

    function automatic t_field_desc field_desc(input logic [ID_W-1:0] id);
        t_field_desc d;
        case (id)
            5'd0:  d = '{7'd3,  2'd1, 1'b0};
            5'd1:  d = '{7'd7,  2'd1, 1'b1};
            5'd2:  d = '{7'd9,  2'd1, 1'b1};
            5'd3:  d = '{7'd11, 2'd1, 1'b1};
            5'd4:  d = '{7'd13, 2'd1, 1'b1};
            5'd5:  d = '{7'd15, 2'd1, 1'b1};
            5'd6:  d = '{7'd17, 2'd1, 1'b1};
            5'd7:  d = '{7'd19, 2'd1, 1'b1};
            5'd8:  d = '{7'd21, 2'd1, 1'b1};
            5'd9:  d = '{7'd23, 2'd1, 1'b1};
            5'd10: d = '{7'd25, 2'd1, 1'b0};
            5'd11: d = '{7'd27, 2'd3, 1'b1};
            5'd12: d = '{7'd31, 2'd3, 1'b1};
            5'd13: d = '{7'd35, 2'd3, 1'b1};
            5'd14: d = '{7'd39, 2'd3, 1'b1};
            5'd15: d = '{7'd43, 2'd3, 1'b1};
            5'd16: d = '{7'd47, 2'd1, 1'b1};
            5'd17: d = '{7'd49, 2'd1, 1'b1};
            5'd18: d = '{7'd51, 2'd1, 1'b1};
            5'd19: d = '{7'd53, 2'd0, 1'b0};
            5'd20: d = '{7'd54, 2'd0, 1'b0};
            5'd21: d = '{7'd55, 2'd1, 1'b1};
            5'd22: d = '{7'd57, 2'd1, 1'b1};
            5'd23: d = '{7'd59, 2'd1, 1'b1};
            5'd24: d = '{7'd61, 2'd1, 1'b1};
            5'd25: d = '{7'd63, 2'd0, 1'b0};
            5'd26: d = '{7'd64, 2'd0, 1'b0};
            5'd27: d = '{7'd65, 2'd0, 1'b0};
            5'd28: d = '{7'd67, 2'd0, 1'b0};
            5'd29: d = '{7'd68, 2'd0, 1'b0};
            5'd30: d = '{7'd69, 2'd0, 1'b0};
            default: d = '{7'd0, 2'd0, 1'b0};
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: design/imu_packet_deframer.sv
// Serial deframer for 74-byte inertial sensor packets. Bytes enter one per cycle on the
// slave stream; a packet opens with 0x10 0x02, closes with 0x10 0x03 and a checksum
// byte, and its bytes are written into a 74-entry byte store as they arrive. A bad
// footer or a bad checksum gives a single error word with tlast set. A good packet is
// read back from the store one byte at a time, a fetch state and a shift state per byte,
// and sent as 31 field words, the last with tlast set; that readout takes 64 store reads
// through the single store read port, and no byte is taken meanwhile. Otherwise a byte
// is taken every cycle the output register is empty or being drained.
`timescale 1ns / 1ps
`default_nettype none

`include "imu_packet_deframer_defines.svh"

module imu_packet_deframer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [4:0] field_id, [36:5] field_value, [39:37] 0
    output logic [1:0]       m_axis_tuser,   // [1:0] kind
    output logic             m_axis_tlast
);

    imu_pd_pkg::t_wr_req             w_wr;
    imu_pd_pkg::t_rd_req             w_rd;
    imu_pd_pkg::t_evt                w_evt;
    logic [7:0]                      w_rdata;
    logic                            w_busy;
    logic                            w_in_fire;
    logic [imu_pd_pkg::ID_W-1:0]     w_id;
    logic [31:0]                     w_value;

    assign s_axis_tready = !w_busy && (!m_axis_tvalid || m_axis_tready);
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tdata  = {3'b000, w_value, w_id};

    imu_pd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_in_fire),
        .i_byte  (s_axis_tdata),
        .o_wr    (w_wr),
        .o_evt   (w_evt)
    );

    imu_pd_store u_store (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_rd    (w_rd),
        .o_rdata (w_rdata)
    );

    imu_pd_readout u_readout (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (w_evt),
        .o_busy  (w_busy),
        .o_rd    (w_rd),
        .i_rdata (w_rdata),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_kind  (m_axis_tuser),
        .o_id    (w_id),
        .o_value (w_value),
        .o_last  (m_axis_tlast)
    );

    `IPD_ASSERT_IMPL(a_err_word_shape, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser != imu_pd_pkg::KIND_FIELD), m_axis_tlast && (m_axis_tdata == 40'd0))
    `IPD_ASSERT_IMPL(a_field_last, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == imu_pd_pkg::KIND_FIELD), m_axis_tlast == (w_id == imu_pd_pkg::LAST_ID))
    `IPD_ASSERT_NEXT(a_go_blocks_input, i_clk, i_rst_n, w_evt.go, !s_axis_tready)
    `IPD_ASSERT_IMPL(a_store_ports_apart, i_clk, i_rst_n, w_rd.en, !w_wr.en)

endmodule

`default_nettype wire

FILE: design/imu_pd_store.sv
`timescale 1ns / 1ps
`default_nettype none

module imu_pd_store (
    input  wire logic                          i_clk,
    input  wire imu_pd_pkg::t_wr_req           i_wr,
    input  wire imu_pd_pkg::t_rd_req           i_rd,
    output logic [7:0]                         o_rdata
);

    logic [7:0] r_mem [imu_pd_pkg::PKT_LEN];

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.addr < 7'(imu_pd_pkg::PKT_LEN))) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            o_rdata <= r_mem[i_rd.addr];
        end
    end

endmodule

`default_nettype wire

FILE: design/imu_pd_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module imu_pd_parser (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic [7:0]            i_byte,
    output imu_pd_pkg::t_wr_req        o_wr,
    output imu_pd_pkg::t_evt           o_evt
);

    typedef enum logic [2:0] {
        P_HDR1 = 3'd0,
        P_HDR2 = 3'd1,
        P_BODY = 3'd2,
        P_ETX  = 3'd3,
        P_BCC  = 3'd4
    } t_phase;

    t_phase                          r_phase, n_phase;
    logic [imu_pd_pkg::ADDR_W-1:0]   r_pos, n_pos;
    logic [7:0]                      r_sum, n_sum;
    logic [7:0]                      w_check;

    // The footer ETX byte is fixed, so fold it into the running sum here.
    assign w_check = r_sum + imu_pd_pkg::ETX_BYTE;

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_sum       = r_sum;
        o_wr.en     = 1'b0;
        o_wr.addr   = r_pos;
        o_wr.data   = i_byte;
        o_evt       = '0;
        if (i_valid) begin
            case (r_phase)
                P_HDR2: begin
                    if (i_byte == imu_pd_pkg::STX_BYTE) begin
                        o_wr.en   = 1'b1;
                        o_wr.addr = imu_pd_pkg::STX_POS;
                        n_pos     = imu_pd_pkg::BODY_POS;
                        n_sum     = '0;
                        n_phase   = P_BODY;
                    end else if (i_byte == imu_pd_pkg::DLE_BYTE) begin
                        // hold at packet start, no position creep
                        o_wr.en   = 1'b1;
                        o_wr.addr = imu_pd_pkg::HDR_POS;
                        n_pos     = imu_pd_pkg::STX_POS;
                    end else begin
                        n_phase = P_HDR1;
                    end
                end
                P_BODY: begin
                    if (r_pos >= imu_pd_pkg::FOOTER_POS) begin
                        if (i_byte == imu_pd_pkg::DLE_BYTE) begin
                            o_wr.en   = 1'b1;
                            o_wr.addr = imu_pd_pkg::FOOTER_POS;
                            n_pos     = imu_pd_pkg::ETX_POS;
                            n_phase   = P_ETX;
                        end else begin
                            o_evt.err  = 1'b1;
                            o_evt.kind = imu_pd_pkg::KIND_FRAME;
                            n_phase    = P_HDR1;
                        end
                    end else begin
                        o_wr.en = 1'b1;
                        n_pos   = r_pos + 7'd1;
                        if (r_pos >= imu_pd_pkg::SUM_FIRST) begin
                            n_sum = r_sum + i_byte;
                        end
                    end
                end
                P_ETX: begin
                    if (i_byte == imu_pd_pkg::ETX_BYTE) begin
                        o_wr.en   = 1'b1;
                        o_wr.addr = imu_pd_pkg::ETX_POS;
                        n_pos     = imu_pd_pkg::BCC_POS;
                        n_phase   = P_BCC;
                    end else begin
                        o_evt.err  = 1'b1;
                        o_evt.kind = imu_pd_pkg::KIND_FRAME;
                        n_phase    = P_HDR1;
                    end
                end
                P_BCC: begin
                    o_wr.en   = 1'b1;
                    o_wr.addr = imu_pd_pkg::BCC_POS;
                    n_pos     = imu_pd_pkg::HDR_POS;
                    n_phase   = P_HDR1;
                    if (w_check != i_byte) begin
                        o_evt.err  = 1'b1;
                        o_evt.kind = imu_pd_pkg::KIND_CSUM;
                    end else begin
                        o_evt.go = 1'b1;
                    end
                end
                default: begin
                    n_phase = P_HDR1;
                    if (i_byte == imu_pd_pkg::DLE_BYTE) begin
                        o_wr.en   = 1'b1;
                        o_wr.addr = imu_pd_pkg::HDR_POS;
                        n_pos     = imu_pd_pkg::STX_POS;
                        n_phase   = P_HDR2;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_HDR1;
            r_pos   <= '0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
        end
        r_sum <= n_sum;
    end

endmodule

`default_nettype wire

FILE: design/imu_pd_readout.sv
`timescale 1ns / 1ps
`default_nettype none

module imu_pd_readout (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire imu_pd_pkg::t_evt              i_evt,
    output logic                               o_busy,
    output imu_pd_pkg::t_rd_req                o_rd,
    input  wire logic [7:0]                    i_rdata,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output imu_pd_pkg::t_kind                  o_kind,
    output logic [imu_pd_pkg::ID_W-1:0]        o_id,
    output logic [31:0]                        o_value,
    output logic                               o_last
);

    typedef enum logic [1:0] {
        R_IDLE  = 2'd0,
        R_FETCH = 2'd1,
        R_SHIFT = 2'd2,
        R_EMIT  = 2'd3
    } t_state;

    t_state                          r_state;
    logic [imu_pd_pkg::ID_W-1:0]     r_id;
    logic [1:0]                      r_idx;
    logic [31:0]                     r_acc;
    imu_pd_pkg::t_field_desc         w_desc;
    logic [31:0]                     w_value;
    logic                            w_out_free;

    assign w_desc     = imu_pd_pkg::field_desc(r_id);
    assign w_out_free = !o_valid || i_ready;
    assign o_busy     = (r_state != R_IDLE);
    assign o_rd.en    = (r_state == R_FETCH);
    assign o_rd.addr  = w_desc.offset + {5'd0, r_idx};

    // Extend the gathered big-endian bytes to 32 bits.
    always_comb begin
        case (w_desc.last_byte)
            2'd0:    w_value = {{24{w_desc.is_signed & r_acc[7]}}, r_acc[7:0]};
            2'd1:    w_value = {{16{w_desc.is_signed & r_acc[15]}}, r_acc[15:0]};
            2'd2:    w_value = {{8{w_desc.is_signed & r_acc[23]}}, r_acc[23:0]};
            default: w_value = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                R_IDLE: begin
                    r_id  <= '0;
                    r_idx <= '0;
                    if (i_evt.err) begin
                        o_valid <= 1'b1;
                        o_kind  <= i_evt.kind;
                        o_id    <= '0;
                        o_value <= '0;
                        o_last  <= 1'b1;
                    end else if (i_evt.go) begin
                        r_state <= R_FETCH;
                    end
                end
                R_FETCH: begin
                    r_state <= R_SHIFT;
                end
                R_SHIFT: begin
                    r_acc <= {r_acc[23:0], i_rdata};
                    if (r_idx == w_desc.last_byte) begin
                        r_state <= R_EMIT;
                    end else begin
                        r_idx   <= r_idx + 2'd1;
                        r_state <= R_FETCH;
                    end
                end
                R_EMIT: begin
                    // hold the field until the output register frees up
                    if (w_out_free) begin
                        o_valid <= 1'b1;
                        o_kind  <= imu_pd_pkg::KIND_FIELD;
                        o_id    <= r_id;
                        o_value <= w_value;
                        o_last  <= (r_id == imu_pd_pkg::LAST_ID);
                        r_idx   <= '0;
                        if (r_id == imu_pd_pkg::LAST_ID) begin
                            r_state <= R_IDLE;
                        end else begin
                            r_id    <= r_id + 5'd1;
                            r_state <= R_FETCH;
                        end
                    end
                end
                default: begin
                    r_state <= R_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import imu_pd_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int MAX_PRINTS   = 30;

    typedef enum logic [2:0] {
        SEEK_DLE, SEEK_STX, IN_BODY, SEEK_ETX, SEEK_BCC
    } t_rx_phase;

    typedef enum int {PKT_GOOD, PKT_BAD_SUM, PKT_BAD_DLE, PKT_BAD_ETX} t_pkt_mode;
    typedef enum int {FILL_RAND, FILL_ZERO, FILL_ONES, FILL_MIN, FILL_MAX} t_fill;

    typedef struct {
        t_kind       kind;
        logic [4:0]  id;
        logic [31:0] value;
        logic        is_last;
    } t_field_word;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;           // [4:0] field_id, [36:5] field_value, [39:37] 0
    logic [1:0]  m_axis_tuser;           // [1:0] kind
    logic        m_axis_tlast;

    imu_packet_deframer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Packet field layout: byte offset, byte count, signedness.
    int field_ofs [NUM_FIELDS] = '{3, 7, 9, 11, 13, 15, 17, 19, 21, 23, 25, 27, 31, 35, 39,
                                   43, 47, 49, 51, 53, 54, 55, 57, 59, 61, 63, 64, 65, 67,
                                   68, 69};
    int field_len [NUM_FIELDS] = '{2, 2, 2, 2, 2, 2, 2, 2, 2, 2, 2, 4, 4, 4, 4, 4, 2, 2, 2,
                                   1, 1, 2, 2, 2, 2, 1, 1, 1, 1, 1, 1};
    bit   field_sgn [NUM_FIELDS] = '{0, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 1, 1, 1, 1, 1, 1, 1,
                                   1, 0, 0, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0};

    t_rx_phase   rx_phase = SEEK_DLE;
    logic [6:0]  rx_pos = '0;
    logic [7:0]  pkt_mem [PKT_LEN];
    t_field_word pending_words [$];

    int  mismatches    = 0;
    int  words_checked = 0;
    int  bytes_sent    = 0;
    int  good_pkts     = 0;
    int  csum_errs     = 0;
    int  frame_errs    = 0;
    int  idle_cycles   = 0;
    int  burst_left    = 0;
    bit  src_active    = 0;
    bit  rst_done      = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        // Cap the log; every mismatch still counts.
        if (mismatches <= MAX_PRINTS)
            $display("%0t mismatch: %s expected %0h got %0h", $realtime, what, want, got);
    endtask

    task automatic post_word(input t_kind kind, input logic [4:0] id,
                             input logic [31:0] value, input logic is_last);
        t_field_word w;
        w.kind    = kind;
        w.id      = id;
        w.value   = value;
        w.is_last = is_last;
        pending_words.push_back(w);
    endtask

    // Advance the parser copy by one accepted byte and queue the words it produces.
    task automatic advance_parser(input logic [7:0] b);
        logic [7:0]         csum;
        logic [31:0]        raw;
        logic signed [31:0] ext;
        int                 sh;
        case (rx_phase)
            SEEK_STX: begin
                if (b == STX_BYTE) begin
                    pkt_mem[STX_POS] = b;
                    rx_pos = BODY_POS;
                    rx_phase = IN_BODY;
                end else if (b == DLE_BYTE) begin
                    pkt_mem[HDR_POS] = b;
                    rx_pos = STX_POS;
                end else begin
                    rx_phase = SEEK_DLE;
                end
            end
            IN_BODY: begin
                if (rx_pos >= FOOTER_POS) begin
                    if (b == DLE_BYTE) begin
                        pkt_mem[FOOTER_POS] = b;
                        rx_pos = ETX_POS;
                        rx_phase = SEEK_ETX;
                    end else begin
                        rx_phase = SEEK_DLE;
                        frame_errs++;
                        post_word(KIND_FRAME, '0, '0, 1'b1);
                    end
                end else begin
                    pkt_mem[rx_pos] = b;
                    rx_pos = rx_pos + 7'd1;
                end
            end
            SEEK_ETX: begin
                if (b == ETX_BYTE) begin
                    pkt_mem[ETX_POS] = b;
                    rx_pos = BCC_POS;
                    rx_phase = SEEK_BCC;
                end else begin
                    rx_phase = SEEK_DLE;
                    frame_errs++;
                    post_word(KIND_FRAME, '0, '0, 1'b1);
                end
            end
            SEEK_BCC: begin
                pkt_mem[BCC_POS] = b;
                rx_pos = '0;
                rx_phase = SEEK_DLE;
                csum = pkt_mem[ETX_POS];
                for (int i = SUM_FIRST; i < FOOTER_POS; i++)
                    csum = csum + pkt_mem[i];
                if (csum != b) begin
                    csum_errs++;
                    post_word(KIND_CSUM, '0, '0, 1'b1);
                end else begin
                    good_pkts++;
                    for (int k = 0; k < NUM_FIELDS; k++) begin
                        raw = '0;
                        for (int i = 0; i < field_len[k]; i++)
                            raw = (raw << 8) | pkt_mem[field_ofs[k] + i];
                        if (field_sgn[k]) begin
                            // Shift up and back arithmetically to extend the sign.
                            sh = 32 - 8 * field_len[k];
                            ext = raw << sh;
                            raw = ext >>> sh;
                        end
                        post_word(KIND_FIELD, k[4:0], raw, k == NUM_FIELDS - 1);
                    end
                end
            end
            default: begin
                rx_phase = SEEK_DLE;
                if (b == DLE_BYTE) begin
                    pkt_mem[HDR_POS] = b;
                    rx_pos = STX_POS;
                    rx_phase = SEEK_STX;
                end
            end
        endcase
    endtask

    // Offer one byte, honoring the burst/gap pattern, and wait for the handshake.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (src_active && burst_left == 0) begin
            gap = $urandom_range(1, 10);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        src_active = 1;
        do @(posedge i_clk); while (!s_axis_tready);
        if (burst_left > 0) burst_left--;
        bytes_sent++;
        advance_parser(b);
    endtask

    // Hold the source off until every pending word has come out.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        src_active = 0;
        do @(posedge i_clk); while (pending_words.size() != 0);
    endtask

    function automatic logic [7:0] byte_not(input logic [7:0] a, input logic [7:0] c);
        logic [7:0] v;
        do v = 8'($urandom); while (v == a || v == c);
        return v;
    endfunction

    task automatic send_packet(input t_pkt_mode mode, input t_fill fill, input int leads);
        logic [7:0] pkt [PKT_LEN];
        logic [7:0] csum;
        for (int i = BODY_POS; i < FOOTER_POS; i++) begin
            case (fill)
                FILL_ZERO: pkt[i] = 8'h00;
                FILL_ONES: pkt[i] = 8'hFF;
                FILL_MIN:  pkt[i] = i[0] ? 8'h80 : 8'h00;
                FILL_MAX:  pkt[i] = i[0] ? 8'h7F : 8'hFF;
                default:   pkt[i] = 8'($urandom);
            endcase
        end
        pkt[FOOTER_POS] = DLE_BYTE;
        pkt[ETX_POS]    = ETX_BYTE;
        csum = ETX_BYTE;
        for (int i = SUM_FIRST; i < FOOTER_POS; i++)
            csum = csum + pkt[i];
        pkt[BCC_POS] = csum;
        case (mode)
            PKT_BAD_SUM: pkt[BCC_POS] = csum + 8'($urandom_range(1, 255));
            PKT_BAD_DLE: pkt[FOOTER_POS] = byte_not(DLE_BYTE, DLE_BYTE);
            PKT_BAD_ETX: pkt[ETX_POS] = byte_not(ETX_BYTE, ETX_BYTE);
            default: ;
        endcase
        repeat (leads) send_byte(DLE_BYTE);
        send_byte(STX_BYTE);
        for (int i = BODY_POS; i < PKT_LEN; i++)
            send_byte(pkt[i]);
    endtask

    task automatic test_header_cases();
        // Stray bytes before any header, extremes included.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(ETX_BYTE);
        send_byte(STX_BYTE);
        // Repeated lead bytes, then a bad second byte.
        send_byte(DLE_BYTE);
        send_byte(DLE_BYTE);
        send_byte(DLE_BYTE);
        send_byte(8'h55);
        send_byte(STX_BYTE);
        send_byte(DLE_BYTE);
        send_byte(8'h00);
        send_byte(DLE_BYTE);
        send_byte(8'hFF);
        send_byte(8'hAA);
        wait_for_results();
    endtask

    task automatic test_good_packets();
        // Signed minimum patterns behind repeated lead bytes.
        send_packet(PKT_GOOD, FILL_MIN, 2);
        wait_for_results();
    endtask

    task automatic test_bad_footer();
        send_packet(PKT_BAD_DLE, FILL_RAND, 1);
        send_packet(PKT_BAD_ETX, FILL_RAND, 2);
        wait_for_results();
    endtask

    task automatic test_bad_checksum();
        send_packet(PKT_BAD_SUM, FILL_RAND, 1);
        wait_for_results();
    endtask

    // Sink stalls: ready follows a 16-bit pattern that is redrawn at random, sometimes always ready.
    logic [15:0] ready_pat = 16'hFFFF;
    int          pat_cnt   = 0;
    always @(posedge i_clk) begin
        pat_cnt <= pat_cnt + 1;
        if (pat_cnt % 48 == 47)
            ready_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        m_axis_tready <= ready_pat[pat_cnt % 16];
    end

    always @(posedge i_clk) begin : check_words
        t_field_word want;
        if (rst_done && m_axis_tvalid && m_axis_tready) begin
            words_checked++;
            if (pending_words.size() == 0) begin
                report_mismatch("word with nothing pending", '0, m_axis_tdata[36:5]);
            end else begin
                want = pending_words.pop_front();
                if (m_axis_tuser !== want.kind)
                    report_mismatch("kind", want.kind, m_axis_tuser);
                if (m_axis_tdata[4:0] !== want.id)
                    report_mismatch("field_id", want.id, m_axis_tdata[4:0]);
                if (m_axis_tdata[36:5] !== want.value)
                    report_mismatch("field_value", want.value, m_axis_tdata[36:5]);
                if (m_axis_tlast !== want.is_last)
                    report_mismatch("last", want.is_last, m_axis_tlast);
            end
        end
    end

    always @(posedge i_clk) begin
        if (rst_done) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    initial begin
        for (int i = 0; i < PKT_LEN; i++) pkt_mem[i] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        rst_done = 1;

        test_header_cases();
        test_good_packets();
        test_bad_footer();
        test_bad_checksum();

        repeat (40) @(posedge i_clk);
        if (pending_words.size() != 0)
            report_mismatch("words never delivered", pending_words.size(), '0);
        $display("covered %0d bytes: %0d good packets, %0d checksum errors, %0d framing errors",
                 bytes_sent, good_pkts, csum_errs, frame_errs);
        $display("checked %0d output words with random source gaps and sink stalls",
                 words_checked);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

FILE: imu_packet_deframer.f
+incdir+design
design/imu_pd_pkg.sv
design/imu_pd_store.sv
design/imu_pd_parser.sv
design/imu_pd_readout.sv
design/imu_packet_deframer.sv
bench/tb.sv
